// ===== rtl/modexp_pkg.sv =====
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Shared widths, the fixed prime and the multiplier request/response words.
// ----------------------------------------------------------------------------
package modexp_pkg;

   localparam int unsigned BASE_WIDTH = 30;
   localparam int unsigned EXP_WIDTH  = 63;
   localparam int unsigned EXP_CNT_W  = $clog2(EXP_WIDTH + 1);
   localparam int unsigned MUL_STEPS  = BASE_WIDTH;
   localparam int unsigned MUL_CNT_W  = $clog2(MUL_STEPS + 1);
   localparam int unsigned ACC_WIDTH  = BASE_WIDTH + 2;

   localparam logic [BASE_WIDTH-1:0] PRIME_MOD = BASE_WIDTH'(1000000007);
   localparam logic [ACC_WIDTH-1:0]  PRIME_X1  = ACC_WIDTH'(1000000007);
   localparam logic [ACC_WIDTH-1:0]  PRIME_X2  = ACC_WIDTH'(2000000014);

   typedef struct packed {
      logic                  start;
      logic [BASE_WIDTH-1:0] mcand;
      logic [BASE_WIDTH-1:0] mplier;
   } mul_req_type;

   typedef struct packed {
      logic                  done;
      logic [BASE_WIDTH-1:0] product;
   } mul_rsp_type;

endpackage

// ===== rtl/modular_exponentiation_core.sv =====
// ----------------------------------------------------------------------------
// Modular exponentiation core
// Base to the power of exponent, modulo 1000000007, by square-and-multiply.
//
// Input words arrive on req_valid/req_ready with req_base and req_exponent;
// results leave on rsp_valid/rsp_ready as rsp_power. One word is worked on at
// a time; req_ready is high whenever no word is in progress.
// Leading zero exponent bits are scanned off one at a time. The first set bit
// loads the base; every later bit costs a squaring and, if set, a multiply.
// Each multiply runs on the one bit-serial multiplier, one step for each of
// the 30 multiplier bits between an issue state and a wait for completion.
// When a result is registered the core returns to idle, where it takes the
// next input word.
// A finished word sits in an output register: a new input word is taken
// while it waits, and only the next completion waits on rsp_ready.
// Reset is synchronous and returns the core to idle with no word held.
// ----------------------------------------------------------------------------
module modular_exponentiation_core
   import modexp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [BASE_WIDTH-1:0] req_base,
   input  logic [EXP_WIDTH-1:0]  req_exponent,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [BASE_WIDTH-1:0] rsp_power
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_SCAN     = 3'd1;
   localparam logic [2:0] S_SQR_GO   = 3'd2;
   localparam logic [2:0] S_SQR_WAIT = 3'd3;
   localparam logic [2:0] S_MUL_GO   = 3'd4;
   localparam logic [2:0] S_MUL_WAIT = 3'd5;
   localparam logic [2:0] S_DONE     = 3'd6;

   logic [2:0]            state_ff, state_in;
   logic [EXP_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [EXP_WIDTH-1:0]  exp_ff, exp_in;
   logic [BASE_WIDTH-1:0] base_ff, base_in;
   logic [BASE_WIDTH-1:0] acc_ff, acc_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [BASE_WIDTH-1:0] rsp_power_ff, rsp_power_in;
   logic [2:0]            next_bit_state;
   logic                  exp_msb;
   mul_req_type           mul_req;
   mul_rsp_type           mul_rsp;

   modexp_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   assign exp_msb        = exp_ff[EXP_WIDTH-1];
   assign next_bit_state = (cnt_ff == EXP_CNT_W'(1)) ? S_DONE : S_SQR_GO;

   always_comb begin
      mul_req.start  = (state_ff == S_SQR_GO) || (state_ff == S_MUL_GO);
      mul_req.mcand  = acc_ff;
      mul_req.mplier = (state_ff == S_MUL_GO) ? base_ff : acc_ff;
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      exp_in       = exp_ff;
      base_in      = base_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_power_in = rsp_power_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               base_in  = (req_base >= PRIME_MOD) ? req_base - PRIME_MOD : req_base;
               exp_in   = req_exponent;
               cnt_in   = EXP_CNT_W'(EXP_WIDTH);
               acc_in   = BASE_WIDTH'(1);
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            exp_in = {exp_ff[EXP_WIDTH-2:0], 1'b0};
            cnt_in = cnt_ff - EXP_CNT_W'(1);
            if (exp_msb) begin
               acc_in   = base_ff;
               state_in = next_bit_state;
            end else if (cnt_ff == EXP_CNT_W'(1)) begin
               state_in = S_DONE;
            end
         end
         S_SQR_GO: begin
            state_in = S_SQR_WAIT;
         end
         S_SQR_WAIT: begin
            if (mul_rsp.done) begin
               acc_in = mul_rsp.product;
               if (exp_msb) begin
                  state_in = S_MUL_GO;
               end else begin
                  exp_in   = {exp_ff[EXP_WIDTH-2:0], 1'b0};
                  cnt_in   = cnt_ff - EXP_CNT_W'(1);
                  state_in = next_bit_state;
               end
            end
         end
         S_MUL_GO: begin
            state_in = S_MUL_WAIT;
         end
         S_MUL_WAIT: begin
            if (mul_rsp.done) begin
               acc_in   = mul_rsp.product;
               exp_in   = {exp_ff[EXP_WIDTH-2:0], 1'b0};
               cnt_in   = cnt_ff - EXP_CNT_W'(1);
               state_in = next_bit_state;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_power_in = acc_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
      exp_ff       <= exp_in;
      base_ff      <= base_in;
      acc_ff       <= acc_in;
      rsp_power_ff <= rsp_power_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_power = rsp_power_ff;

`ifndef SYNTHESIS
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      mul_rsp.done |-> (state_ff == S_SQR_WAIT || state_ff == S_MUL_WAIT))
      else $error("multiplier completion outside a wait state");

   a_acc_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE && state_ff != S_SCAN) |-> (acc_ff < PRIME_MOD))
      else $error("running value not reduced");

   a_rsp_reduced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_power < PRIME_MOD))
      else $error("result word not reduced");
`endif

endmodule

// ===== rtl/modexp_mul.sv =====
// ----------------------------------------------------------------------------
// Bit-serial modular multiplier
// Interleaved multiply and reduce, one multiplier bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module modexp_mul
   import modexp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mul_req_type mul_req,
   output mul_rsp_type mul_rsp
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [MUL_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [BASE_WIDTH-1:0] a_ff, a_in;
   logic [BASE_WIDTH-1:0] m_ff, m_in;
   logic [BASE_WIDTH-1:0] r_ff, r_in;
   logic [ACC_WIDTH-1:0]  sum;
   logic [ACC_WIDTH-1:0]  sum_red;

   always_comb begin
      sum = {1'b0, r_ff, 1'b0} + (m_ff[BASE_WIDTH-1] ? {2'b00, a_ff} : '0);
      if (sum >= PRIME_X2) begin
         sum_red = sum - PRIME_X2;
      end else if (sum >= PRIME_X1) begin
         sum_red = sum - PRIME_X1;
      end else begin
         sum_red = sum;
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      m_in    = m_ff;
      r_in    = r_ff;
      if (mul_req.start) begin
         busy_in = 1'b1;
         cnt_in  = MUL_CNT_W'(MUL_STEPS);
         a_in    = mul_req.mcand;
         m_in    = mul_req.mplier;
         r_in    = '0;
      end else if (busy_ff) begin
         r_in   = sum_red[BASE_WIDTH-1:0];
         m_in   = {m_ff[BASE_WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - MUL_CNT_W'(1);
         if (cnt_ff == MUL_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_ff <= a_in;
      m_ff <= m_in;
      r_ff <= r_in;
   end

   assign mul_rsp.done    = done_ff;
   assign mul_rsp.product = r_ff;

endmodule

// ===== bench/modexp_power_checker.sv =====
// ----------------------------------------------------------------------------
// Modular exponentiation power checker
// Watches the request and response channels of the core, works out each
// power from the accepted base and exponent by square-and-multiply, and
// compares every response word with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module modexp_power_checker
   import modexp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [BASE_WIDTH-1:0] req_base,
   input  logic [EXP_WIDTH-1:0]  req_exponent,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [BASE_WIDTH-1:0] rsp_power,
   output int unsigned           outstanding,
   output int unsigned           fail_count
);

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [63:0] PRIME_VALUE = 64'(PRIME_MOD);

   logic [BASE_WIDTH-1:0] power_queue[$];

   function automatic logic [BASE_WIDTH-1:0] predict_power(input logic [BASE_WIDTH-1:0] base,
                                                           input logic [EXP_WIDTH-1:0] exponent);
      logic [63:0] acc;
      logic [63:0] reduced;
      reduced = 64'(base);
      if (reduced >= PRIME_VALUE) begin
         reduced = reduced - PRIME_VALUE;
      end
      acc = 64'd1;
      for (int i = EXP_WIDTH - 1; i >= 0; i--) begin
         acc = (acc * acc) % PRIME_VALUE;
         if (exponent[i]) begin
            acc = (acc * reduced) % PRIME_VALUE;
         end
      end
      return acc[BASE_WIDTH-1:0];
   endfunction

   always @(posedge clock) begin
      logic [BASE_WIDTH-1:0] wanted;
      if (reset) begin
         power_queue.delete();
         fail_count <= 0;
      end else begin
         if (req_valid && req_ready) begin
            power_queue = {power_queue, predict_power(req_base, req_exponent)};
         end
         if (rsp_valid && rsp_ready) begin
            if (power_queue.size() == 0) begin
               $error("power: no word outstanding, actual %0d", rsp_power);
               fail_count <= fail_count + 1;
            end else begin
               wanted = power_queue.pop_front();
               if (rsp_power !== wanted) begin
                  $error("power mismatch: expected %0d, actual %0d", wanted, rsp_power);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      outstanding <= power_queue.size();
   end

endmodule

// ===== bench/modular_exponentiation_core_tb.sv =====
// ----------------------------------------------------------------------------
// Modular exponentiation core testbench
// Drives directed and random base/exponent words into the core under three
// idling mixes on both channels, with one full drain per mix, and reports
// the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module modular_exponentiation_core_tb
   import modexp_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned PRIME_INT  = 1000000007;
   localparam int unsigned BASE_TOP   = (1 << BASE_WIDTH) - 1;
   localparam int unsigned PHASE_WORDS = 133;
   localparam int unsigned TAIL_CYCLES = 4100;

   logic                  clock        = 1'b0;
   logic                  reset        = 1'b1;
   logic                  req_valid    = 1'b0;
   logic                  req_ready;
   logic [BASE_WIDTH-1:0] req_base     = '0;
   logic [EXP_WIDTH-1:0]  req_exponent = '0;
   logic                  rsp_valid;
   logic                  rsp_ready    = 1'b0;
   logic [BASE_WIDTH-1:0] rsp_power;

   int unsigned outstanding;
   int unsigned fail_count;
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;

   modular_exponentiation_core uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_base     (req_base),
      .req_exponent (req_exponent),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_power    (rsp_power)
   );

   modexp_power_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_base     (req_base),
      .req_exponent (req_exponent),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_power    (rsp_power),
      .outstanding  (outstanding),
      .fail_count   (fail_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   initial begin
      #80_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   task automatic send_word(input logic [BASE_WIDTH-1:0] base,
                            input logic [EXP_WIDTH-1:0] exponent);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_base     <= base;
      req_exponent <= exponent;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // hold the sender off until every word has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      @(negedge clock);
   endtask

   function automatic logic [BASE_WIDTH-1:0] random_base();
      if ($urandom_range(0, 99) < 10) begin
         return BASE_WIDTH'($urandom_range(PRIME_INT, BASE_TOP));
      end
      return BASE_WIDTH'($urandom_range(0, PRIME_INT - 1));
   endfunction

   // mostly short exponents, a few full width
   function automatic logic [EXP_WIDTH-1:0] random_exponent();
      int unsigned pick;
      int unsigned len;
      logic [63:0] bits;
      logic [63:0] mask;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         len = $urandom_range(0, 12);
      end else if (pick < 90) begin
         len = $urandom_range(13, 40);
      end else begin
         len = EXP_WIDTH;
      end
      bits = {$urandom, $urandom};
      mask = (64'd1 << len) - 64'd1;
      return EXP_WIDTH'(bits & mask);
   endfunction

   task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int n = 0; n < PHASE_WORDS; n++) begin
         if (n == 60) begin
            drain_results();
         end
         send_word(random_base(), random_exponent());
      end
   endtask

   initial begin
      logic [EXP_WIDTH-1:0] all_ones;
      all_ones = '1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 30;
      recv_idle_pct = 57;
      send_word('0, '0);
      send_word('0, EXP_WIDTH'(1));
      send_word('0, all_ones);
      send_word(BASE_WIDTH'(1), all_ones);
      send_word(BASE_WIDTH'(PRIME_INT - 1), '0);
      send_word(BASE_WIDTH'(PRIME_INT - 1), EXP_WIDTH'(1));
      send_word(BASE_WIDTH'(PRIME_INT - 1), EXP_WIDTH'(2));
      send_word(BASE_WIDTH'(PRIME_INT - 1), all_ones);
      send_word(BASE_WIDTH'(2), EXP_WIDTH'(30));
      send_word(BASE_WIDTH'(2), EXP_WIDTH'(64'd1 << 62));
      send_word(BASE_WIDTH'(PRIME_INT), EXP_WIDTH'(5));
      send_word(BASE_WIDTH'(PRIME_INT), '0);
      send_word(BASE_WIDTH'(PRIME_INT + 1), all_ones);
      send_word(BASE_WIDTH'(BASE_TOP), '0);
      send_word(BASE_WIDTH'(BASE_TOP), EXP_WIDTH'(1));
      send_word(BASE_WIDTH'(BASE_TOP), all_ones);
      send_word(BASE_WIDTH'(12345), EXP_WIDTH'(PRIME_INT - 2));
      send_word(BASE_WIDTH'(3), EXP_WIDTH'(64'h5555_5555_5555_5555));
      send_word(BASE_WIDTH'(7), EXP_WIDTH'(64'h2AAA_AAAA_AAAA_AAAA));

      run_phase(30, 57);
      run_phase(57, 30);
      run_phase(0, 0);

      req_valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
